@@ rtl/rtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc_pkg - shared types and constants for the telegram CRC-8 checker
// Type table, register map, verdict codes and the byte-wide CRC-8 step.
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int unsigned TYPE_TABLE_ENTRIES = 7;

  localparam logic [7:0] TYPE_CODES [TYPE_TABLE_ENTRIES] = '{
    8'h00, 8'h01, 8'h03, 8'h83, 8'hA3, 8'hE7, 8'h90
  };
  localparam logic [7:0] TYPE_LENGTHS [TYPE_TABLE_ENTRIES] = '{
    8'd8, 8'd8, 8'd11, 8'd10, 8'd10, 8'd8, 8'd9
  };

  localparam logic [7:0] STANDSTILL_TYPE = 8'h90;

  // Register map (index = paddr[3:2])
  localparam int unsigned ADDR_W = 4;
  typedef enum logic [1:0] {
    REG_CRC_POLY    = 2'd0,
    REG_CRC_INIT    = 2'd1,
    REG_DEFAULT_LEN = 2'd2,
    REG_SHORT_WA    = 2'd3
  } reg_idx_t;

  localparam logic [7:0] RESET_CRC_POLY    = 8'h2F;
  localparam logic [7:0] RESET_CRC_INIT    = 8'hAA;
  localparam logic [7:0] RESET_DEFAULT_LEN = 8'd16;
  localparam logic       RESET_SHORT_WA    = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_PASS      = 2'd0,
    VERDICT_PASS_SHORT = 2'd1,
    VERDICT_CRC_FAIL  = 2'd2,
    VERDICT_TOO_SHORT = 2'd3
  } verdict_t;

  localparam logic [7:0] MIN_CHECK_LEN = 8'd4;

  typedef struct packed {
    logic [7:0] crc_poly;
    logic [7:0] crc_init;
    logic [7:0] default_length;
    logic       short_workaround_enable;
  } rtc_cfg_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] telegram_type;
    logic [7:0] expected_length;
    logic [7:0] received_length;
  } rtc_result_t;

  // Expected length for a type byte; unknown types take the default
  function automatic logic [7:0] lookup_length(input logic [7:0] type_byte,
                                               input logic [7:0] dflt);
    logic [7:0] len;
    len = dflt;
    for (int k = TYPE_TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (TYPE_CODES[k] == type_byte) begin
        len = TYPE_LENGTHS[k];
      end
    end
    return len;
  endfunction

  // One byte of MSB-first CRC-8, no reflection
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/rtc_ifs.sv @@
// ----------------------------------------------------------------------------
// rtc_ifs - valid/ready channels of the telegram CRC-8 checker
// Byte input channel and verdict result channel.
// ----------------------------------------------------------------------------
interface rtc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rtc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [7:0] telegram_type;
  logic [7:0] expected_length;
  logic [7:0] received_length;

  modport source (output valid, output verdict, output telegram_type,
                  output expected_length, output received_length, input ready);
  modport sink   (input valid, input verdict, input telegram_type,
                  input expected_length, input received_length, output ready);
endinterface

@@ rtl/rf_telegram_crc8_checker.sv @@
// ----------------------------------------------------------------------------
// rf_telegram_crc8_checker - CRC-8 frame check of received radio telegrams
// Byte input register, combinational check logic, verdict output register.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, with the result channel ready.
// The verdict is registered as the final byte leaves the input register.
// The per-byte loop (type lookup, byte-wide CRC-8, position compare) closes
// through the telegram state registers of the check core.
// Reset (rst_n, synchronous): both channels empty, telegram state cleared,
// registers to polynomial 0x2F, start 0xAA, default length 16, option on.
// ----------------------------------------------------------------------------
module rf_telegram_crc8_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  rtc_in_if.sink                     in_chan,
  rtc_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [rtc_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  rtc_pkg::rtc_cfg_t    cfg;
  rtc_pkg::rtc_result_t res;

  // Input register
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;

  // Result register
  logic                 out_valid_r;
  rtc_pkg::rtc_result_t out_res_r;

  logic in_xfer;
  logic out_free;
  logic s1_adv;

  rtc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rtc_check_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (s1_adv),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .result    (res)
  );

  // A middle byte leaves the input register freely; a final byte needs room
  // in the result register, which frees up in the same cycle it is taken.
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; load on every transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  // Load the verdict on a final byte, drop it once the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.verdict         = out_res_r.verdict;
  assign out_chan.telegram_type   = out_res_r.telegram_type;
  assign out_chan.expected_length = out_res_r.expected_length;
  assign out_chan.received_length = out_res_r.received_length;

  // Too short exactly when three or fewer bytes arrived
  a_too_short_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_res_r.received_length < rtc_pkg::MIN_CHECK_LEN) ==
                     (out_res_r.verdict == rtc_pkg::VERDICT_TOO_SHORT)))
    else $error("too-short verdict disagrees with received length");

  // Short-length pass only for the standstill type
  a_short_type : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.verdict == rtc_pkg::VERDICT_PASS_SHORT)) |->
      (out_res_r.telegram_type == rtc_pkg::STANDSTILL_TYPE))
    else $error("short-length pass on a non-standstill telegram");

  // A held final byte means the result register is full and stalled
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> (s1_last_r && out_valid_r && !out_chan.ready))
    else $error("input register stalled without a blocked result");

  // A verdict appears only after a final byte left the input register
  a_load_src : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result loaded without a final byte");

endmodule

@@ rtl/rtc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rtc_cfg_regs - APB configuration registers
// Holds polynomial, start value, default length and the short-length option.
// ----------------------------------------------------------------------------
module rtc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rtc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rtc_pkg::rtc_cfg_t          cfg
);

  rtc_pkg::rtc_cfg_t cfg_r;
  rtc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = rtc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_poly                <= rtc_pkg::RESET_CRC_POLY;
      cfg_r.crc_init                <= rtc_pkg::RESET_CRC_INIT;
      cfg_r.default_length          <= rtc_pkg::RESET_DEFAULT_LEN;
      cfg_r.short_workaround_enable <= rtc_pkg::RESET_SHORT_WA;
    end else if (wr_en) begin
      case (idx)
        rtc_pkg::REG_CRC_POLY:    cfg_r.crc_poly                <= pwdata[7:0];
        rtc_pkg::REG_CRC_INIT:    cfg_r.crc_init                <= pwdata[7:0];
        rtc_pkg::REG_DEFAULT_LEN: cfg_r.default_length          <= pwdata[7:0];
        rtc_pkg::REG_SHORT_WA:    cfg_r.short_workaround_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rtc_pkg::REG_CRC_POLY:    prdata = {24'd0, cfg_r.crc_poly};
      rtc_pkg::REG_CRC_INIT:    prdata = {24'd0, cfg_r.crc_init};
      rtc_pkg::REG_DEFAULT_LEN: prdata = {24'd0, cfg_r.default_length};
      rtc_pkg::REG_SHORT_WA:    prdata = {31'd0, cfg_r.short_workaround_enable};
      default:                  prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/rtc_check_core.sv @@
// ----------------------------------------------------------------------------
// rtc_check_core - per-telegram state and verdict logic
// Runs the CRC, tracks the byte position and builds the verdict per byte.
// ----------------------------------------------------------------------------
module rtc_check_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rtc_pkg::rtc_cfg_t    cfg,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output rtc_pkg::rtc_result_t result
);

  logic [7:0] cnt_r,  cnt_nxt;
  logic [7:0] crc_r,  crc_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] len_r,  len_nxt;
  logic       full_r, full_nxt;
  logic       short_r, short_nxt;

  logic       first;
  logic [7:0] crc_before;
  logic [7:0] cur_type;
  logic [7:0] cur_len;
  logic       crc_hit;
  logic       full_pos;
  logic       short_pos;
  logic       full_m;
  logic       short_m;
  logic [7:0] cnt_inc;
  logic [7:0] crc_after;

  assign first      = (cnt_r == 8'd0);
  assign crc_before = first ? cfg.crc_init : crc_r;
  assign cur_type   = first ? data_byte : type_r;
  assign cur_len    = first ? rtc_pkg::lookup_length(data_byte, cfg.default_length)
                            : len_r;
  assign crc_hit    = (data_byte == crc_before);
  assign full_pos   = (cur_len >= 8'd1) && (cnt_r == cur_len - 8'd1);
  assign short_pos  = (cur_len >= 8'd2) && (cnt_r == cur_len - 8'd2);
  assign full_m     = full_r  | (full_pos  & crc_hit);
  assign short_m    = short_r | (short_pos & crc_hit);
  assign cnt_inc    = (cnt_r == 8'hFF) ? 8'hFF : cnt_r + 8'd1;
  assign crc_after  = rtc_pkg::crc8_byte(crc_before, data_byte, cfg.crc_poly);

  always_comb begin
    result.telegram_type   = cur_type;
    result.expected_length = cur_len;
    result.received_length = cnt_inc;
    if (cnt_inc < rtc_pkg::MIN_CHECK_LEN) begin
      result.verdict = rtc_pkg::VERDICT_TOO_SHORT;
    end else if (full_m) begin
      result.verdict = rtc_pkg::VERDICT_PASS;
    end else if (cfg.short_workaround_enable && (cur_type == rtc_pkg::STANDSTILL_TYPE)
                 && short_m) begin
      result.verdict = rtc_pkg::VERDICT_PASS_SHORT;
    end else begin
      result.verdict = rtc_pkg::VERDICT_CRC_FAIL;
    end
  end

  // Clear after the final byte, otherwise carry the telegram forward
  always_comb begin
    if (last_byte) begin
      cnt_nxt   = 8'd0;
      crc_nxt   = cfg.crc_init;
      type_nxt  = 8'd0;
      len_nxt   = 8'd0;
      full_nxt  = 1'b0;
      short_nxt = 1'b0;
    end else begin
      cnt_nxt   = cnt_inc;
      crc_nxt   = crc_after;
      type_nxt  = cur_type;
      len_nxt   = cur_len;
      full_nxt  = full_m;
      short_nxt = short_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 8'd0;
      crc_r   <= rtc_pkg::RESET_CRC_INIT;
      type_r  <= 8'd0;
      len_r   <= 8'd0;
      full_r  <= 1'b0;
      short_r <= 1'b0;
    end else if (step) begin
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      full_r  <= full_nxt;
      short_r <= short_nxt;
    end
  end

endmodule
